### rtl/core/bmpd_pkg.sv
// Shared types, constants and helpers for the 1-bpp BMP stream decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bmpd_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int DIM_W         = $clog2(MAX_DIM + 2);
  localparam int MAX_ROW_BYTES = (MAX_DIM + 1 + 7) / 8;
  localparam int MAX_STRIDE    = ((MAX_ROW_BYTES + 3) / 4) * 4;
  localparam int STRIDE_W      = $clog2(MAX_STRIDE + 1);
  localparam int COL_W         = STRIDE_W + 3;
  localparam int COORD_W       = 13;
  localparam int DEST_W        = 12;
  localparam int POS_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int JOBQ_DEPTH    = 2;

  localparam logic [15:0] SIG_BM = 16'h4D42;
  localparam logic [1:0]  PAL_RESET = 2'b10;

  // header byte positions
  localparam logic [POS_W-1:0] POS_SIG      = 32'd1;
  localparam logic [POS_W-1:0] POS_OFFSET   = 32'd13;
  localparam logic [POS_W-1:0] POS_WIDTH    = 32'd21;
  localparam logic [POS_W-1:0] POS_HEIGHT   = 32'd25;
  localparam logic [POS_W-1:0] POS_DEPTH    = 32'd29;
  localparam logic [POS_W-1:0] POS_COMPR    = 32'd33;
  localparam logic [POS_W-1:0] POS_PALCNT   = 32'd49;
  localparam logic [POS_W-1:0] POS_HDR_LAST = 32'd53;
  localparam logic [POS_W-1:0] HDR_LEN      = 32'd54;
  localparam logic [POS_W-1:0] PAL0_AT      = 32'h36;
  localparam logic [POS_W-1:0] PAL1_AT      = 32'h3A;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIG   = 3'd1,
    ST_NOT_MONO  = 3'd2,
    ST_BAD_PAL   = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  // one queued job: a header status or one data byte worth of pixels
  typedef struct packed {
    logic               is_status;
    status_t            status;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x_base;
    logic [7:0]         data;
    logic [1:0]         pal;
    logic [2:0]         last_k;
  } job_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    status_t            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v > POS_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM + 1);
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bmpd_front.sv
// Front end: parses header bytes, tracks row/column position and turns each
// accepted byte into at most one job. Depends on bmpd_pkg.
`default_nettype none

module bmpd_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          acc,
  input  wire  [7:0]                   file_byte,
  input  wire                          sof,
  input  wire  [bmpd_pkg::DEST_W-1:0]  dest_x,
  input  wire  [bmpd_pkg::DEST_W-1:0]  dest_y,
  output logic                         job_push,
  output bmpd_pkg::job_t               job
);
  import bmpd_pkg::*;

  localparam int CW0 = (DIM_W > COL_W) ? DIM_W : COL_W;
  localparam int CW  = ((CW0 > COORD_W) ? CW0 : COORD_W) + 1;

  logic [POS_W-1:0]    pos_r, pos_b, pos_nxt;
  logic [31:0]         shift_r, shift_b, shift_nxt;
  logic                sig_ok_r, sig_ok_b, sig_ok_nxt;
  logic [POS_W-1:0]    dstart_r, dstart_b, dstart_nxt;
  logic [DIM_W-1:0]    width_r, width_b, width_nxt;
  logic [DIM_W-1:0]    height_r, height_b, height_nxt;
  logic                bpp_bad_r, bpp_bad_b, bpp_bad_nxt;
  logic                comp_bad_r, comp_bad_b, comp_bad_nxt;
  logic                pal_nz_r, pal_nz_b, pal_nz_nxt;
  logic                pal_bad_r, pal_bad_b, pal_bad_nxt;
  logic [1:0]          pal_r, pal_b, pal_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_b, stride_nxt;
  logic [DIM_W-1:0]    row_r, row_b, row_nxt;
  logic [STRIDE_W-1:0] bir_r, bir_b, bir_nxt;
  logic                halted_r, halted_b, halted_nxt;

  logic                nz;
  status_t             st;
  logic [DIM_W:0]      row_bytes;
  logic [DIM_W:0]      stride_full;
  logic [COL_W-1:0]    col0;
  logic [CW-1:0]       rem;
  logic [CW-1:0]       x_sum;
  logic [CW-1:0]       y_sum;
  logic [STRIDE_W:0]   bir_inc;

  always_comb begin
    // a new file starts from cleared parse state
    pos_b      = sof ? '0 : pos_r;
    shift_b    = sof ? '0 : shift_r;
    sig_ok_b   = sof ? 1'b0 : sig_ok_r;
    dstart_b   = sof ? '0 : dstart_r;
    width_b    = sof ? '0 : width_r;
    height_b   = sof ? '0 : height_r;
    bpp_bad_b  = sof ? 1'b0 : bpp_bad_r;
    comp_bad_b = sof ? 1'b0 : comp_bad_r;
    pal_nz_b   = sof ? 1'b0 : pal_nz_r;
    pal_bad_b  = sof ? 1'b0 : pal_bad_r;
    pal_b      = sof ? PAL_RESET : pal_r;
    stride_b   = sof ? '0 : stride_r;
    row_b      = sof ? '0 : row_r;
    bir_b      = sof ? '0 : bir_r;
    halted_b   = sof ? 1'b0 : halted_r;

    pos_nxt      = (pos_b == '1) ? pos_b : pos_b + POS_W'(1);
    shift_nxt    = shift_b;
    sig_ok_nxt   = sig_ok_b;
    dstart_nxt   = dstart_b;
    width_nxt    = width_b;
    height_nxt   = height_b;
    bpp_bad_nxt  = bpp_bad_b;
    comp_bad_nxt = comp_bad_b;
    pal_nz_nxt   = pal_nz_b;
    pal_bad_nxt  = pal_bad_b;
    pal_nxt      = pal_b;
    stride_nxt   = stride_b;
    row_nxt      = row_b;
    bir_nxt      = bir_b;
    halted_nxt   = halted_b;

    nz          = file_byte != 8'd0;
    st          = ST_OK;
    row_bytes   = (DIM_W + 1)'({1'b0, width_b} + (DIM_W + 1)'(7)) >> 3;
    stride_full = (row_bytes + (DIM_W + 1)'(3)) & ~(DIM_W + 1)'(3);
    col0        = {bir_b, 3'b000};
    rem         = CW'(width_b) - CW'(col0);
    x_sum       = CW'(dest_x) + CW'(col0);
    y_sum       = CW'(dest_y) + CW'(height_b) - CW'(row_b) - CW'(1);
    bir_inc     = (STRIDE_W + 1)'(bir_b) + (STRIDE_W + 1)'(1);

    job_push   = 1'b0;
    job        = '0;
    job.x_base = x_sum[COORD_W-1:0];
    job.y      = y_sum[COORD_W-1:0];
    job.data   = file_byte;

    if (!halted_b) begin
      if (pos_b < HDR_LEN) begin
        shift_nxt = {file_byte, shift_b[31:8]};
        unique case (pos_b)
          POS_SIG:    sig_ok_nxt = shift_nxt[31:16] == SIG_BM;
          POS_OFFSET: dstart_nxt = shift_nxt;
          POS_WIDTH:  width_nxt = clamp_dim(shift_nxt);
          POS_HEIGHT: height_nxt = clamp_dim(shift_nxt);
          POS_DEPTH:  bpp_bad_nxt = shift_nxt[31:16] > 16'd1;
          POS_COMPR:  comp_bad_nxt = shift_nxt != 32'd0;
          POS_PALCNT: begin
            pal_nz_nxt  = shift_nxt != 32'd0;
            pal_bad_nxt = (shift_nxt != 32'd0) && (shift_nxt != 32'd2);
          end
          POS_HDR_LAST: begin
            // later failing check wins
            if (!sig_ok_b) st = ST_BAD_SIG;
            if (bpp_bad_b || comp_bad_b) st = ST_NOT_MONO;
            if (pal_bad_b) st = ST_BAD_PAL;
            if (width_b > DIM_W'(MAX_DIM) || height_b > DIM_W'(MAX_DIM)) st = ST_TOO_LARGE;
            halted_nxt   = st != ST_OK;
            pal_nxt      = PAL_RESET;
            stride_nxt   = stride_full[STRIDE_W-1:0];
            row_nxt      = '0;
            bir_nxt      = '0;
            job_push     = 1'b1;
            job.is_status = 1'b1;
            job.status   = st;
            job.last_k   = 3'd0;
          end
          default: ;
        endcase
      end else begin
        // palette words: low three bytes of each decide the entry
        if (pal_nz_b) begin
          if (pos_b == PAL0_AT) begin
            pal_nxt[0] = nz;
          end else if (pos_b == PAL0_AT + POS_W'(1) || pos_b == PAL0_AT + POS_W'(2)) begin
            pal_nxt[0] = pal_b[0] | nz;
          end else if (pos_b == PAL1_AT) begin
            pal_nxt[1] = nz;
          end else if (pos_b == PAL1_AT + POS_W'(1) || pos_b == PAL1_AT + POS_W'(2)) begin
            pal_nxt[1] = pal_b[1] | nz;
          end
        end
        if (pos_b >= dstart_b && stride_b != '0 && row_b < height_b) begin
          if (CW'(width_b) > CW'(col0)) begin
            job_push   = 1'b1;
            job.last_k = (rem >= CW'(8)) ? 3'd7 : rem[2:0] - 3'd1;
          end
          job.pal = pal_nxt;
          if (bir_inc >= (STRIDE_W + 1)'(stride_b)) begin
            bir_nxt = '0;
            row_nxt = row_b + DIM_W'(1);
          end else begin
            bir_nxt = bir_inc[STRIDE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      shift_r    <= '0;
      sig_ok_r   <= 1'b0;
      dstart_r   <= '0;
      width_r    <= '0;
      height_r   <= '0;
      bpp_bad_r  <= 1'b0;
      comp_bad_r <= 1'b0;
      pal_nz_r   <= 1'b0;
      pal_bad_r  <= 1'b0;
      pal_r      <= PAL_RESET;
      stride_r   <= '0;
      row_r      <= '0;
      bir_r      <= '0;
      halted_r   <= 1'b0;
    end else if (acc) begin
      pos_r      <= pos_nxt;
      shift_r    <= shift_nxt;
      sig_ok_r   <= sig_ok_nxt;
      dstart_r   <= dstart_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      bpp_bad_r  <= bpp_bad_nxt;
      comp_bad_r <= comp_bad_nxt;
      pal_nz_r   <= pal_nz_nxt;
      pal_bad_r  <= pal_bad_nxt;
      pal_r      <= pal_nxt;
      stride_r   <= stride_nxt;
      row_r      <= row_nxt;
      bir_r      <= bir_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmpd_job_q.sv
// Short job queue between the parsing front end and the pixel expander.
// Depends on bmpd_pkg for the job type and depth.
`default_nettype none

module bmpd_job_q (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  bmpd_pkg::job_t      push_job,
  input  wire                 pop,
  output bmpd_pkg::job_t      head,
  output bmpd_pkg::q_stat_t   stat
);
  import bmpd_pkg::*;

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             mem_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = cnt_r == CNT_W'(JOBQ_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmpd_back.sv
// Back end: expands one job into its results in an output register, one per
// cycle while that register is empty or popped. Depends on bmpd_pkg.
`default_nettype none

module bmpd_back (
  input  wire                clk,
  input  wire                rst_n,
  input  bmpd_pkg::job_t     head,
  input  bmpd_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  input  wire                out_pop,
  output logic               out_valid,
  output bmpd_pkg::result_t  res
);
  import bmpd_pkg::*;

  job_t    cur_r;
  logic    cur_v_r, cur_v_nxt;
  logic [2:0] k_r, k_nxt;
  logic    ov_r, ov_nxt;
  result_t res_r, res_nxt;
  logic    adv, finish;

  assign adv    = cur_v_r && (!ov_r || out_pop);
  assign finish = adv && (k_r == cur_r.last_k);
  assign q_pop  = !q_stat.empty && (!cur_v_r || finish);

  always_comb begin
    res_nxt        = '0;
    res_nxt.kind   = cur_r.is_status;
    res_nxt.status = cur_r.is_status ? cur_r.status : ST_OK;
    res_nxt.last   = k_r == cur_r.last_k;
    if (!cur_r.is_status) begin
      res_nxt.x  = cur_r.x_base + COORD_W'(k_r);
      res_nxt.y  = cur_r.y;
      // MSB first: bit 7-k, and ~k is 7-k on three bits
      res_nxt.on = cur_r.pal[cur_r.data[~k_r]];
    end
  end

  always_comb begin
    cur_v_nxt = cur_v_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r;
    if (out_pop) ov_nxt = 1'b0;
    if (adv) begin
      ov_nxt = 1'b1;
      k_nxt  = k_r + 3'd1;
    end
    if (finish) cur_v_nxt = 1'b0;
    if (q_pop) begin
      cur_v_nxt = 1'b1;
      k_nxt     = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      k_r     <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= head;
    if (adv) res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### rtl/core/mono_bmp_stream_decoder.sv
// Top level of the 1-bpp BMP stream decoder: configuration registers, front
// parser, job queue and pixel expander. Depends on bmpd_pkg and bmpd_* modules.
`default_nettype none

// Takes a 1-bit-per-pixel BMP file one byte per push. Header bytes 0..53 give
// no results except one status item on byte 53 (0 ok, else the later failing
// check); a nonzero status halts the decoder until a byte with
// in_start_of_file set. Each pixel data byte yields up to 8 pixel items,
// MSB first, in file order (bottom row first, y already flipped, padding
// dropped), with dest_x/dest_y added. out_last_of_run marks the final item of
// one byte and is set on every status item. Input bytes are taken one per
// cycle while the two-entry job queue has room; the expander emits one item
// per cycle whenever its output register is empty or popped in that cycle.
// Write dest_x (index 0) and dest_y (index 1) only while the block is idle.
module mono_bmp_stream_decoder (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_push,
  output logic                             in_full,
  input  wire  [7:0]                       in_file_byte,
  input  wire                              in_start_of_file,
  output logic                             out_empty,
  input  wire                              out_pop,
  output logic                             out_result_kind,
  output logic [bmpd_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [bmpd_pkg::COORD_W-1:0]     out_pixel_y,
  output logic                             out_pixel_on,
  output logic [bmpd_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_last_of_run,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bmpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bmpd_pkg::DEST_W-1:0]      cfg_data
);
  import bmpd_pkg::*;

  logic [DEST_W-1:0] dest_x_r, dest_y_r;
  logic              acc;
  logic              job_push;
  job_t              job, head;
  q_stat_t           q_stat;
  logic              q_pop;
  logic              out_valid;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r <= '0;
      dest_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEST_X: dest_x_r <= cfg_data;
        CFG_DEST_Y: dest_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = q_stat.full;
  assign acc     = in_push && !in_full;

  bmpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .file_byte(in_file_byte),
    .sof      (in_start_of_file),
    .dest_x   (dest_x_r),
    .dest_y   (dest_y_r),
    .job_push (job_push),
    .job      (job)
  );

  bmpd_job_q u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (acc && job_push),
    .push_job(job),
    .pop     (q_pop),
    .head    (head),
    .stat    (q_stat)
  );

  bmpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_valid(out_valid),
    .res      (res)
  );

  assign out_empty       = !out_valid;
  assign out_result_kind = res.kind;
  assign out_pixel_x     = res.x;
  assign out_pixel_y     = res.y;
  assign out_pixel_on    = res.on;
  assign out_status      = res.status;
  assign out_last_of_run = res.last;

  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && job_push) |-> !q_stat.full)
    else $error("job queue written while full");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && !out_pixel_on && out_last_of_run))
    else $error("status item carries pixel fields");

  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_result_kind) |-> (out_status == ST_OK))
    else $error("pixel item with nonzero status");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop) |-> !q_stat.empty)
    else $error("expander took a job from an empty queue");

endmodule

`default_nettype wire
